### sv/ile_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg: shared types for the indexed list engine
// Operation and status codes, and the command word broadcast to the cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_UNSHIFT = 4'd1,
    OP_POP     = 4'd2,
    OP_SHIFT   = 4'd3,
    OP_INSERT  = 4'd4,
    OP_REMOVE  = 4'd5,
    OP_GET     = 4'd6,
    OP_PUT     = 4'd7,
    OP_REVERSE = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell does with its entry.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0, // hold
    CMD_WRITE = 2'd1, // overwrite the addressed cell
    CMD_OPEN  = 2'd2, // write the addressed cell; cells above it take the left neighbor
    CMD_CLOSE = 2'd3  // cells at or above the address take the right neighbor
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [DataW-1:0] wdata;
  } cell_cmd_t;

endpackage
`default_nettype wire

### sv/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result beat is registered in the output register, or in the skid stage while
// the output register is stalled. One operation per cycle while in_stall_o is low;
// every operation, reverse included, is a single parallel step of the cell row.
// in_stall_o rises only while both the output register and the skid stage hold beats.
// Reset clears the entry count, the direction flag and both valid flags; entry values
// are not cleared and stay unknown until written.
// ----------------------------------------------------------------------------
// indexed_list_engine_unit: bounded ordered list of raw 64-bit values
// Row of entry cells with push, unshift, pop, shift, insert, remove, get,
// put and reverse, one result beat per operation.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input channel
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [3:0]                           operation_i,
  input  wire  [$clog2(DEPTH)-1:0]             position_i,
  input  wire  [ile_pkg::DataW-1:0]            item_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [ile_pkg::DataW-1:0]            read_value_o,
  output logic [1:0]                           status_o,
  output logic [$clog2(DEPTH+1)-1:0]           count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
  localparam logic [CW-1:0] OneCnt  = CW'(1);

  // --------------------------------------------------------------------------
  // List state. The cells hold the entries in physical order; rev_q says the
  // logical list runs from the top occupied cell down to cell 0. Reverse
  // then only flips rev_q, and the back and front swap roles.
  // --------------------------------------------------------------------------
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rev_q, rev_d;

  logic acc;
  logic take;
  logic skid_v_q;
  logic out_v_q;

  assign in_stall_o = skid_v_q;
  assign acc        = in_valid_i && !skid_v_q;
  assign take       = out_v_q && !out_stall_i;

  logic [CW-1:0] pos_x;
  logic [CW-1:0] cnt_m1;
  logic          full;
  logic          empty;
  logic          in_range;
  logic [AW-1:0] q_at;   // physical cell of logical position
  logic [AW-1:0] q_ins;  // physical cell that receives an inserted value

  assign pos_x    = CW'(position_i);
  assign cnt_m1   = cnt_q - OneCnt;
  assign full     = (cnt_q == FullCnt);
  assign empty    = (cnt_q == '0);
  assign in_range = (pos_x < cnt_q);
  // Reversed, logical p lives at count-1-p, and inserting before it lands
  // just above that cell, at count-p.
  assign q_at     = rev_q ? AW'(cnt_m1 - pos_x) : AW'(pos_x);
  assign q_ins    = rev_q ? AW'(cnt_q - pos_x) : AW'(pos_x);

  ile_pkg::cmd_e    kind;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    raddr;
  logic             rd_en;
  ile_pkg::status_e st;

  // Decode the operation into one row command plus a read address.
  always_comb begin
    kind  = ile_pkg::CMD_NONE;
    addr  = '0;
    raddr = '0;
    rd_en = 1'b0;
    st    = ile_pkg::ST_OK;
    cnt_d = cnt_q;
    rev_d = rev_q;
    case (ile_pkg::op_e'(operation_i))
      ile_pkg::OP_PUSH: begin
        if (full) begin
          st = ile_pkg::ST_FULL;
        end else begin
          kind  = rev_q ? ile_pkg::CMD_OPEN : ile_pkg::CMD_WRITE;
          addr  = rev_q ? '0 : AW'(cnt_q);
          cnt_d = cnt_q + OneCnt;
        end
      end
      ile_pkg::OP_UNSHIFT: begin
        if (full) begin
          st = ile_pkg::ST_FULL;
        end else begin
          kind  = rev_q ? ile_pkg::CMD_WRITE : ile_pkg::CMD_OPEN;
          addr  = rev_q ? AW'(cnt_q) : '0;
          cnt_d = cnt_q + OneCnt;
        end
      end
      ile_pkg::OP_POP: begin
        if (empty) begin
          st = ile_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          raddr = rev_q ? '0 : AW'(cnt_m1);
          kind  = rev_q ? ile_pkg::CMD_CLOSE : ile_pkg::CMD_NONE;
          cnt_d = cnt_m1;
        end
      end
      ile_pkg::OP_SHIFT: begin
        if (empty) begin
          st = ile_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          raddr = rev_q ? AW'(cnt_m1) : '0;
          kind  = rev_q ? ile_pkg::CMD_NONE : ile_pkg::CMD_CLOSE;
          cnt_d = cnt_m1;
        end
      end
      ile_pkg::OP_INSERT: begin
        if (!in_range) begin
          st = ile_pkg::ST_RANGE;
        end else if (full) begin
          st = ile_pkg::ST_FULL;
        end else begin
          kind  = ile_pkg::CMD_OPEN;
          addr  = q_ins;
          cnt_d = cnt_q + OneCnt;
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (!in_range) begin
          st = ile_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          raddr = q_at;
          kind  = ile_pkg::CMD_CLOSE;
          addr  = q_at;
          cnt_d = cnt_m1;
        end
      end
      ile_pkg::OP_GET: begin
        if (!in_range) begin
          st = ile_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
          raddr = q_at;
        end
      end
      ile_pkg::OP_PUT: begin
        if (!in_range) begin
          st = ile_pkg::ST_RANGE;
        end else begin
          kind = ile_pkg::CMD_WRITE;
          addr = q_at;
        end
      end
      ile_pkg::OP_REVERSE: begin
        rev_d = !rev_q;
      end
      default: begin
        kind = ile_pkg::CMD_NONE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Cell row. Drop the command to a hold when no beat is accepted.
  // --------------------------------------------------------------------------
  ile_pkg::cell_cmd_t        cmd;
  logic [ile_pkg::DataW-1:0] cell_val [DEPTH];

  assign cmd.kind  = acc ? kind : ile_pkg::CMD_NONE;
  assign cmd.wdata = item_value_i;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [ile_pkg::DataW-1:0] left_w;
    logic [ile_pkg::DataW-1:0] right_w;
    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_w = cell_val[gi];
    end else begin : g_mid_r
      assign right_w = cell_val[gi+1];
    end
    ile_cell #(
      .AW  (AW),
      .IDX (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .addr_i  (addr),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[gi])
    );
  end

  logic [ile_pkg::DataW-1:0] rd_val;
  assign rd_val = rd_en ? cell_val[raddr] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rev_q <= 1'b0;
    end else if (acc) begin
      cnt_q <= cnt_d;
      rev_q <= rev_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result path: output register plus one skid stage, so a beat is still
  // accepted while the output register waits on a stall.
  // --------------------------------------------------------------------------
  logic [ile_pkg::DataW-1:0] out_rd_q, skid_rd_q;
  ile_pkg::status_e          out_st_q, skid_st_q;
  logic [CW-1:0]             out_cnt_q, skid_cnt_q;
  logic                      out_load;
  logic                      skid_load;

  assign out_load  = !out_v_q || take;
  assign skid_load = acc && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q  <= skid_v_q || acc;
        skid_v_q <= 1'b0;
      end else if (skid_load) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_v_q) begin
        out_rd_q  <= skid_rd_q;
        out_st_q  <= skid_st_q;
        out_cnt_q <= skid_cnt_q;
      end else begin
        out_rd_q  <= rd_val;
        out_st_q  <= st;
        out_cnt_q <= cnt_d;
      end
    end
    if (skid_load) begin
      skid_rd_q  <= rd_val;
      skid_st_q  <= st;
      skid_cnt_q <= cnt_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;
  assign count_o      = out_cnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count above depth");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a beat while the output register is empty");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && st != ile_pkg::ST_OK) |=> (cnt_q == $past(cnt_q) && rev_q == $past(rev_q)))
    else $error("rejected operation changed the list");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && operation_i == ile_pkg::OP_PUSH && !full) |=> cnt_q == $past(cnt_q) + OneCnt)
    else $error("push did not grow the list");

endmodule
`default_nettype wire

### sv/ile_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ile_cell: one list entry
// Holds one value; writes, or takes a neighbor's value on a shift.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int unsigned AW  = 4,
  parameter int unsigned IDX = 0
) (
  input  wire                         clk_i,
  input  wire ile_pkg::cell_cmd_t     cmd_i,
  input  wire  [AW-1:0]               addr_i,
  input  wire  [ile_pkg::DataW-1:0]   left_i,
  input  wire  [ile_pkg::DataW-1:0]   right_i,
  output logic [ile_pkg::DataW-1:0]   value_o
);

  localparam logic [AW-1:0] IdxA = AW'(IDX);

  logic [ile_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.kind)
      ile_pkg::CMD_WRITE: begin
        if (addr_i == IdxA) value_d = cmd_i.wdata;
      end
      ile_pkg::CMD_OPEN: begin
        if (addr_i == IdxA) value_d = cmd_i.wdata;
        else if (addr_i < IdxA) value_d = left_i;
      end
      ile_pkg::CMD_CLOSE: begin
        if (addr_i <= IdxA) value_d = right_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

### tb/tb_indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine_unit: self-checking bench for the indexed list engine
// Drives list operations through the valid/stall input channel, keeps a mirror
// of the list to predict every result beat, and compares each accepted result
// field by field under random sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_unit;
  import ile_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PosW         = $clog2(DEPTH);
  localparam int unsigned CountW       = $clog2(DEPTH + 1);
  localparam int unsigned RandomItems  = 2000;
  // Upper bound on the whole run, set well above the slowest legal run of 2k beats
  // with the longest receiver stalls and sender gaps.
  localparam int unsigned CycleLimit   = 400000;
  // Settling time after the last reply, before the verdict.
  localparam int unsigned SettleCycles = 16;

  // Operation codes the block must ignore.
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // Sender mix: grow the list, shrink it, or spread over every code.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SPREAD} op_mix_e;
  // Receiver stall patterns.
  typedef enum int {RX_OPEN, RX_SPOTTY, RX_LONG} rx_pattern_e;

  typedef struct {
    logic [DataW-1:0]  read_value;
    status_e           status;
    logic [CountW-1:0] count;
  } list_reply_t;

  // Mirror of the list contents; predicts one reply per accepted operation
  // and holds the replies still owed by the block.
  class list_mirror;
    logic [DataW-1:0] slot [DEPTH];
    int unsigned      fill = 0;
    list_reply_t      replies_due[$];
    int unsigned      errors = 0;

    function void note_op(logic [3:0] op, logic [PosW-1:0] pos, logic [DataW-1:0] val);
      list_reply_t      r;
      bit               in_range;
      bit               full;
      int unsigned      i;
      int unsigned      lo;
      int unsigned      hi;
      logic [DataW-1:0] tmp;
      r.read_value = '0;
      r.status     = ST_OK;
      in_range     = (pos < fill);
      full         = (fill >= DEPTH);
      case (op)
        OP_PUSH: begin
          if (full) begin
            r.status = ST_FULL;
          end else begin
            slot[fill] = val;
            fill++;
          end
        end
        OP_UNSHIFT: begin
          if (full) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > 0; i--) slot[i] = slot[i - 1];
            slot[0] = val;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_RANGE;
          end else begin
            fill--;
            r.read_value = slot[fill];
          end
        end
        OP_SHIFT: begin
          if (fill == 0) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = slot[0];
            for (i = 0; i + 1 < fill; i++) slot[i] = slot[i + 1];
            fill--;
          end
        end
        OP_INSERT: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else if (full) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) slot[i] = slot[i - 1];
            slot[pos] = val;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = slot[pos];
            for (i = pos; i + 1 < fill; i++) slot[i] = slot[i + 1];
            fill--;
          end
        end
        OP_GET: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = slot[pos];
          end
        end
        OP_PUT: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else begin
            slot[pos] = val;
          end
        end
        OP_REVERSE: begin
          lo = 0;
          hi = fill;
          while (hi > lo + 1) begin
            hi--;
            tmp      = slot[lo];
            slot[lo] = slot[hi];
            slot[hi] = tmp;
            lo++;
          end
        end
        default: begin
        end
      endcase
      r.count = CountW'(fill);
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [DataW-1:0] rd, logic [1:0] st, logic [CountW-1:0] cnt);
      list_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with nothing pending: read_value=%h status=%0d count=%0d",
                 $time, rd, st, cnt);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (rd !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value, rd);
          errors++;
        end
        if (st !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, st);
          errors++;
        end
        if (cnt !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [3:0]        operation_i;
  logic [PosW-1:0]   position_i;
  logic [DataW-1:0]  item_value_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DataW-1:0]  read_value_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] count_o;

  list_mirror  lm = new;
  int unsigned cycle_count = 0;

  rx_pattern_e rx_pattern = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned stall_left = 0;

  indexed_list_engine_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: switch between never stalling, stalling on a 30 percent chance and
  // holding off for random runs of stalls; each pattern lasts a while.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_left = 0;
      stall_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_e'($urandom_range(RX_OPEN, RX_LONG));
        rx_left    = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_pattern)
        RX_OPEN: out_stall_i <= 1'b0;
        RX_SPOTTY: out_stall_i <= ($urandom_range(0, 99) < 30);
        default: begin
          if (stall_left > 0) begin
            out_stall_i <= 1'b1;
            stall_left--;
          end else begin
            out_stall_i <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // Check every result beat that the receiver takes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      lm.check_reply(read_value_o, status_o, count_o);
    end
  end

  // Present one operation beat and hold it until the block takes it. Valid
  // stays high on return; the caller either lowers it or presents the next beat.
  task automatic drive_beat(input logic [3:0] op, input logic [PosW-1:0] pos,
                            input logic [DataW-1:0] val);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lm.note_op(op, pos, val);
  endtask

  initial begin
    logic [3:0]       op;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] val;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      burst_left;
    int unsigned      gap;
    bit               quiet;
    op_mix_e          mix;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_PUSH;
    position_i   <= '0;
    item_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operation but unshift on the empty list, the one-entry reverse,
    // out-of-range positions, insert at the count, unused codes, then drain.
    drive_beat(OP_POP,     '0, '0);
    drive_beat(OP_SHIFT,   '0, '0);
    drive_beat(OP_GET,     '0, '0);
    drive_beat(OP_REMOVE,  '0, '0);
    drive_beat(OP_PUT,     '0, '1);
    drive_beat(OP_INSERT,  '0, '1);
    drive_beat(OP_REVERSE, '0, '0);
    drive_beat(OP_PUSH,    '1, '1);
    drive_beat(OP_REVERSE, '0, '0);
    drive_beat(OP_UNSHIFT, '0, '0);
    drive_beat(OP_INSERT,  PosW'(1), 64'h5555_5555_5555_5555);
    drive_beat(OP_GET,     PosW'(2), '0);
    drive_beat(OP_GET,     '1, '0);
    drive_beat(OP_PUT,     '0, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_beat(OP_REVERSE, '0, '0);
    drive_beat(OP_INSERT,  PosW'(3), 64'h0123_4567_89AB_CDEF);
    drive_beat(OP_UNUSED_LO, '0, '0);
    drive_beat(OP_UNUSED_HI, '1, '1);
    drive_beat(OP_REMOVE,  PosW'(1), '0);
    drive_beat(OP_SHIFT,   '0, '0);
    drive_beat(OP_POP,     '0, '0);
    drive_beat(OP_POP,     '0, '0);

    // Random: swing the list between empty and full so the full, empty and
    // range cases all come up, with bursts, gaps and quiet stretches.
    mix        = MIX_FILL;
    burst_left = 0;
    for (n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 39) == 0) mix = op_mix_e'($urandom_range(MIX_FILL, MIX_SPREAD));
      if (mix == MIX_FILL && lm.fill == DEPTH && $urandom_range(0, 3) == 0) mix = MIX_DRAIN;
      if (mix == MIX_DRAIN && lm.fill == 0 && $urandom_range(0, 3) == 0) mix = MIX_FILL;

      pick = $urandom_range(0, 99);
      op   = 4'($urandom_range(OP_PUSH, OP_REVERSE));
      case (mix)
        MIX_FILL: begin
          if (pick < 35) op = OP_PUSH;
          else if (pick < 55) op = OP_UNSHIFT;
          else if (pick < 75) op = OP_INSERT;
        end
        MIX_DRAIN: begin
          if (pick < 30) op = OP_POP;
          else if (pick < 50) op = OP_SHIFT;
          else if (pick < 70) op = OP_REMOVE;
        end
        default: begin
          if (pick < 6) op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
      endcase

      // Mostly land inside the list; sometimes anywhere, out of range included.
      if (lm.fill != 0 && $urandom_range(0, 4) != 0) pos = PosW'($urandom_range(0, lm.fill - 1));
      else pos = PosW'($urandom_range(0, DEPTH - 1));

      case ($urandom_range(0, 7))
        0: val = '0;
        1: val = '1;
        default: val = {$urandom, $urandom};
      endcase

      drive_beat(op, pos, val);

      if (n == RandomItems / 2 || $urandom_range(0, 299) == 0) begin
        // Hold off until the block has answered everything.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (lm.replies_due.size() != 0);
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        quiet      = ($urandom_range(0, 3) == 0);
        burst_left = quiet ? $urandom_range(50, 150) : $urandom_range(1, 12);
        if (!quiet) begin
          gap = $urandom_range(1, 6);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (lm.replies_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (lm.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/ile_pkg.sv
sv/ile_cell.sv
sv/indexed_list_engine_unit.sv
tb/tb_indexed_list_engine_unit.sv
